>>> rtl/core/mctcd_pkg.sv
package mctcd_pkg;

  // Charset codes
  localparam logic [2:0] CS_UTF8    = 3'd0;
  localparam logic [2:0] CS_UTF16LE = 3'd1;
  localparam logic [2:0] CS_UTF16BE = 3'd2;
  localparam logic [2:0] CS_UTF32LE = 3'd3;
  localparam logic [2:0] CS_UTF32BE = 3'd4;

  // Register indexes
  localparam logic REG_CHARSET = 1'b0;
  localparam logic REG_STOP    = 1'b1;

  localparam logic [31:0] REPL_CP     = 32'h0000_FFFD;
  localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;
  localparam logic [31:0] MAX_CP      = 32'h0010_FFFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [5:0]  HIGH_SURR   = 6'b110110;
  localparam logic [5:0]  LOW_SURR    = 6'b110111;

  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;

  typedef enum logic [1:0] {
    KIND_CP      = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_BAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] assembly_word;
    logic [1:0]  bytes_pending;
    logic [1:0]  byte_phase;
    logic [15:0] held_high_surrogate;
    logic        surrogate_held;
    logic        decode_stopped;
    logic [15:0] emitted_count;
  } str_state_t;

  typedef struct packed {
    logic        end_of_run;
    logic [15:0] char_count;
    logic [31:0] char_value;
    kind_t       kind;
  } result_t;

endpackage

>>> rtl/core/mctcd_decode.sv
module mctcd_decode (
  input  mctcd_pkg::str_state_t st_i,
  input  logic [2:0]            charset_i,
  input  logic                  stop_on_invalid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output mctcd_pkg::str_state_t st_o,
  output mctcd_pkg::result_t    res_o [mctcd_pkg::MAX_RES],
  output logic [1:0]            n_res_o
);

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    sat_inc = (c == mctcd_pkg::COUNT_MAX) ? c : c + 16'd1;
  endfunction

  function automatic mctcd_pkg::result_t mk_cp(input logic [31:0] cp);
    mctcd_pkg::result_t r;
    r.end_of_run = 1'b0;
    r.char_count = '0;
    r.char_value = cp;
    r.kind       = mctcd_pkg::KIND_CP;
    mk_cp = r;
  endfunction

  always_comb begin
    mctcd_pkg::str_state_t st;
    mctcd_pkg::result_t    res [mctcd_pkg::MAX_RES];
    mctcd_pkg::kind_t      end_kind;
    logic [1:0]            n;
    logic [15:0]           unit;
    logic [31:0]           cp;
    logic                  big;

    st       = st_i;
    n        = 2'd0;
    unit     = '0;
    cp       = '0;
    end_kind = mctcd_pkg::KIND_END_OK;
    big      = (charset_i == mctcd_pkg::CS_UTF16BE) || (charset_i == mctcd_pkg::CS_UTF32BE);
    for (int i = 0; i < mctcd_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    case (charset_i)
      mctcd_pkg::CS_UTF8: begin
        if (!st.decode_stopped) begin
          if (st.bytes_pending != 2'd0) begin
            st.assembly_word = {st.assembly_word[25:0], data_byte_i[5:0]};
            st.bytes_pending = st.bytes_pending - 2'd1;
            if (st.bytes_pending == 2'd0) begin
              cp = st.assembly_word;
              if (st.byte_phase == 2'd3 &&
                  (cp < mctcd_pkg::SUPP_BASE || cp > mctcd_pkg::MAX_CP)) begin
                cp = mctcd_pkg::REPL_CP;
              end
              res[n] = mk_cp(cp);
              n = n + 2'd1;
              st.emitted_count = sat_inc(st.emitted_count);
              st.assembly_word = '0;
              st.byte_phase    = 2'd0;
            end
          end else if (!data_byte_i[7]) begin
            res[n] = mk_cp({24'd0, data_byte_i});
            n = n + 2'd1;
            st.emitted_count = sat_inc(st.emitted_count);
          end else if (data_byte_i[7:5] == 3'b110) begin
            st.assembly_word = {27'd0, data_byte_i[4:0]};
            st.bytes_pending = 2'd1;
            st.byte_phase    = 2'd1;
          end else if (data_byte_i[7:4] == 4'b1110) begin
            st.assembly_word = {28'd0, data_byte_i[3:0]};
            st.bytes_pending = 2'd2;
            st.byte_phase    = 2'd2;
          end else if (data_byte_i[7:3] == 5'b11110) begin
            st.assembly_word = {29'd0, data_byte_i[2:0]};
            st.bytes_pending = 2'd3;
            st.byte_phase    = 2'd3;
          end else if (stop_on_invalid_i) begin
            st.decode_stopped = 1'b1;
          end else begin
            res[n] = mk_cp(mctcd_pkg::REPL_CP);
            n = n + 2'd1;
            st.emitted_count = sat_inc(st.emitted_count);
          end
        end
      end
      mctcd_pkg::CS_UTF16LE, mctcd_pkg::CS_UTF16BE: begin
        if (st.byte_phase == 2'd0) begin
          st.assembly_word = {24'd0, data_byte_i};
          st.byte_phase    = 2'd1;
        end else begin
          unit = big ? {st.assembly_word[7:0], data_byte_i}
                     : {data_byte_i, st.assembly_word[7:0]};
          st.assembly_word = '0;
          st.byte_phase    = 2'd0;
          if (st.surrogate_held && unit[15:10] == mctcd_pkg::LOW_SURR) begin
            // combine the pair
            cp = {12'd0, st.held_high_surrogate[9:0], unit[9:0]} + mctcd_pkg::SUPP_BASE;
            res[n] = mk_cp(cp);
            n = n + 2'd1;
            st.emitted_count       = sat_inc(st.emitted_count);
            st.surrogate_held      = 1'b0;
            st.held_high_surrogate = '0;
          end else begin
            if (st.surrogate_held) begin
              res[n] = mk_cp({16'd0, st.held_high_surrogate});
              n = n + 2'd1;
              st.emitted_count       = sat_inc(st.emitted_count);
              st.surrogate_held      = 1'b0;
              st.held_high_surrogate = '0;
            end
            if (unit[15:10] == mctcd_pkg::HIGH_SURR) begin
              st.held_high_surrogate = unit;
              st.surrogate_held      = 1'b1;
            end else begin
              res[n] = mk_cp({16'd0, unit});
              n = n + 2'd1;
              st.emitted_count = sat_inc(st.emitted_count);
            end
          end
        end
      end
      mctcd_pkg::CS_UTF32LE, mctcd_pkg::CS_UTF32BE: begin
        if (big) begin
          st.assembly_word = {st.assembly_word[23:0], data_byte_i};
        end else begin
          st.assembly_word[{st.byte_phase, 3'b000} +: 8] = data_byte_i;
        end
        if (st.byte_phase == 2'd3) begin
          res[n] = mk_cp(st.assembly_word);
          n = n + 2'd1;
          st.emitted_count = sat_inc(st.emitted_count);
          st.assembly_word = '0;
          st.byte_phase    = 2'd0;
        end else begin
          st.byte_phase = st.byte_phase + 2'd1;
        end
      end
      default: begin
        // unused charset: drop the byte
      end
    endcase

    if (last_byte_i) begin
      if (charset_i > mctcd_pkg::CS_UTF32BE) begin
        end_kind = mctcd_pkg::KIND_END_BAD;
      end else if (charset_i != mctcd_pkg::CS_UTF8) begin
        if (st.surrogate_held) begin
          res[n] = mk_cp({16'd0, st.held_high_surrogate});
          n = n + 2'd1;
          st.emitted_count  = sat_inc(st.emitted_count);
          st.surrogate_held = 1'b0;
        end
        if (st.byte_phase != 2'd0) begin
          end_kind = mctcd_pkg::KIND_END_BAD;
        end
      end
      res[n].end_of_run = 1'b1;
      res[n].char_count = st.emitted_count;
      res[n].char_value = '0;
      res[n].kind       = end_kind;
      n = n + 2'd1;
      st = '0;
    end

    st_o    = st;
    res_o   = res;
    n_res_o = n;
  end

endmodule

>>> rtl/core/multi_charset_to_codepoint_decoder.sv
// Decodes a byte stream in UTF-8, UTF-16LE/BE or UTF-32LE/BE (chosen by the
// charset register) into Unicode code points, one byte accepted per clock
// while the queue has room. Each byte is decoded in the cycle it is taken and
// its results (none, one, two or three words: code points and, after the byte
// marked tlast, an end word carrying the character count and the kind) go
// into a four-entry result queue that drains one word per cycle while
// out_tready is high. A byte that yields several results can hold off later
// bytes while the queue drains. The input is taken while at most one word
// waits (two if one is being taken). Write the registers only while the
// block is idle; a charset write clears any partly decoded string.
module multi_charset_to_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] char_value, [47:32] char_count
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // end_of_run
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [2:0]            charset_r;
  logic                  stop_r;
  mctcd_pkg::str_state_t st_r, st_nxt, st_dec;
  mctcd_pkg::result_t    res   [mctcd_pkg::MAX_RES];
  logic [1:0]            n_res;
  mctcd_pkg::result_t    q_r   [mctcd_pkg::QDEPTH];
  mctcd_pkg::result_t    q_nxt [mctcd_pkg::QDEPTH];
  logic [2:0]            cnt_r, cnt_nxt;
  logic                  cfg_wr, in_acc, out_acc;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == mctcd_pkg::REG_CHARSET) ? {29'd0, charset_r}
                                                               : {31'd0, stop_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_r <= mctcd_pkg::CS_UTF8;
      stop_r    <= 1'b1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == mctcd_pkg::REG_CHARSET) begin
        charset_r <= cfg_pwdata[2:0];
      end else begin
        stop_r <= cfg_pwdata[0];
      end
    end
  end

  mctcd_decode u_decode (
    .st_i              (st_r),
    .charset_i         (charset_r),
    .stop_on_invalid_i (stop_r),
    .data_byte_i       (in_tdata),
    .last_byte_i       (in_tlast),
    .st_o              (st_dec),
    .res_o             (res),
    .n_res_o           (n_res)
  );

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {q_r[0].char_count, q_r[0].char_value};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].end_of_run;
  assign out_acc    = out_tvalid & out_tready;
  // room for a full burst of results after this cycle's pop
  assign in_tready  = (cnt_r <= 3'd1) || ((cnt_r == 3'd2) && out_tready);
  assign in_acc     = in_tvalid & in_tready;

  always_comb begin
    st_nxt = st_r;
    if (cfg_wr && cfg_paddr[2] == mctcd_pkg::REG_CHARSET) begin
      st_nxt = '0;
    end else if (in_acc) begin
      st_nxt = st_dec;
    end
  end

  always_comb begin
    mctcd_pkg::result_t sh [mctcd_pkg::QDEPTH];
    logic [2:0] base;
    logic [2:0] off;

    for (int i = 0; i < mctcd_pkg::QDEPTH - 1; i++) begin
      sh[i] = out_acc ? q_r[i+1] : q_r[i];
    end
    sh[mctcd_pkg::QDEPTH-1] = q_r[mctcd_pkg::QDEPTH-1];
    base = cnt_r - {2'd0, out_acc};
    for (int i = 0; i < mctcd_pkg::QDEPTH; i++) begin
      off = 3'(i) - base;
      if (3'(i) < base) begin
        q_nxt[i] = sh[i];
      end else if (in_acc && off < {1'b0, n_res}) begin
        q_nxt[i] = res[off[1:0]];
      end else begin
        q_nxt[i] = sh[i];
      end
    end
    cnt_nxt = base + (in_acc ? {1'b0, n_res} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

>>> rtl/core/mctcd_checker.sv
module mctcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[31:0] == 32'd0
      && (out_tuser == mctcd_pkg::KIND_END_OK || out_tuser == mctcd_pkg::KIND_END_BAD))
    else $error("end word with code point or wrong kind");

  a_cp_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == mctcd_pkg::KIND_CP
      && out_tdata[47:32] == 16'd0)
    else $error("code point word with end fields");

  // the last byte always leaves an end word behind it
  a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_pready)
    else $error("output valid after reset");

endmodule

bind multi_charset_to_codepoint_decoder mctcd_checker u_mctcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
